### src/rsc_pkg.sv
package rsc_pkg;

   localparam int RSC_STACK_DEPTH = 128;

   // Token modes as they arrive on the request channel.
   localparam logic [2:0] MODE_PUSH     = 3'd0;
   localparam logic [2:0] MODE_ADD      = 3'd1;
   localparam logic [2:0] MODE_SUB      = 3'd2;
   localparam logic [2:0] MODE_MUL      = 3'd3;
   localparam logic [2:0] MODE_DIV      = 3'd4;
   localparam logic [2:0] MODE_LINE_END = 3'd5;
   localparam logic [2:0] MODE_UNKNOWN  = 3'd6;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DIV = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN  = 2'd3;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } stk_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_B,
      ST_TAKE_B,
      ST_POP_A,
      ST_TAKE_A,
      ST_CALC,
      ST_PUSH,
      ST_DONE
   } rsc_state_type;

endpackage

### src/rpn_stack_calculator_core.sv
// Throughput: one token at a time; the next token is accepted only after the result of the
// last one is loaded into the output register, so the bit-serial unit (32 steps, 48 for
// divide) sets the rate, and a result that finds a stalled beat still in the output
// register waits until that beat is taken. Reset (synchronous, active high) empties the
// stack and drops any pending result; the stack memory itself is not cleared.
module rpn_stack_calculator_core import rsc_pkg::*; #(
   parameter int STACK_DEPTH = RSC_STACK_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   // Sequencer state and the token being worked on.
   rsc_state_type   state_ff,     state_in;
   logic [CW-1:0]   count_ff,     count_in;
   logic [2:0]      mode_ff,      mode_in;
   logic [31:0]     value_ff,     value_in;
   logic [1:0]      status_ff,    status_in;
   logic [31:0]     b_ff,         b_in;
   logic            hit_ff,       hit_in;

   // Output register, so a finished beat can wait while the core moves on.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff,  rsp_data_in;

   stk_ctrl_type    stk_ctrl;
   logic [31:0]     stk_rd_data;
   logic [AW-1:0]   top_addr;
   logic [AW-1:0]   push_addr;
   logic [CW-1:0]   count_dec;
   logic            stack_empty;
   logic            stack_room;
   logic [31:0]     popped;

   alu_cmd_type     alu_cmd;
   logic            alu_busy;
   logic [31:0]     alu_result;

   logic            req_take;
   logic            out_load;

   assign count_dec   = count_ff - CW'(1);
   assign top_addr    = count_dec[AW-1:0];
   assign push_addr   = count_ff[AW-1:0];
   assign stack_empty = (count_ff == '0);
   assign stack_room  = (count_ff < CW'(STACK_DEPTH));
   // A pop from an empty stack reads as zero.
   assign popped      = hit_ff ? stk_rd_data : 32'd0;
   assign req_take    = req_valid && !req_stall;

   rsc_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .ADDR_WIDTH  (AW)
   ) u_stack (
      .clock   (clock),
      .ctrl    (stk_ctrl),
      .wr_addr (push_addr),
      .wr_data (value_ff),
      .rd_addr (top_addr),
      .rd_data (stk_rd_data)
   );

   rsc_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .a_opnd (popped),
      .b_opnd (b_ff),
      .busy   (alu_busy),
      .result (alu_result)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_data.mode)
                  MODE_PUSH:                                  state_in = ST_PUSH;
                  MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV,
                  MODE_LINE_END:                              state_in = ST_POP_B;
                  default:                                    state_in = ST_DONE;
               endcase
            end
         end
         ST_POP_B:  state_in = ST_TAKE_B;
         ST_TAKE_B: begin
            // A line end is finished once the top is read, and a zero divisor
            // aborts the divide with the dividend left in place.
            if (mode_ff == MODE_LINE_END || (mode_ff == MODE_DIV && popped == 32'd0)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_POP_A;
            end
         end
         ST_POP_A:  state_in = ST_TAKE_A;
         ST_TAKE_A: state_in = ST_CALC;
         ST_CALC: begin
            if (!alu_busy) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH:   state_in = ST_DONE;
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_stall      = 1'b1;
      stk_ctrl.rd_en = 1'b0;
      stk_ctrl.wr_en = 1'b0;
      alu_cmd.start  = 1'b0;
      alu_cmd.op     = ALU_ADD;
      out_load       = 1'b0;
      case (state_ff)
         ST_IDLE:           req_stall = 1'b0;
         ST_POP_B, ST_POP_A: stk_ctrl.rd_en = !stack_empty;
         ST_TAKE_A: begin
            alu_cmd.start = 1'b1;
            case (mode_ff)
               MODE_ADD: alu_cmd.op = ALU_ADD;
               MODE_SUB: alu_cmd.op = ALU_SUB;
               MODE_MUL: alu_cmd.op = ALU_MUL;
               default:  alu_cmd.op = ALU_DIV;
            endcase
         end
         ST_PUSH:           stk_ctrl.wr_en = stack_room;
         ST_DONE:           out_load = !rsp_valid_ff || !rsp_stall;
         default:           req_stall = 1'b1;
      endcase
   end

   // Datapath next values.
   always_comb begin
      count_in     = count_ff;
      mode_in      = mode_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      b_in         = b_ff;
      hit_in       = hit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (req_take) begin
         mode_in = req_data.mode;
         if (req_data.mode inside {MODE_PUSH, MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV,
                                   MODE_LINE_END}) begin
            status_in = STATUS_OK;
            value_in  = req_data.operand;
         end else begin
            status_in = STATUS_UNKNOWN;
            value_in  = 32'd0;
         end
      end

      if (state_ff == ST_POP_B || state_ff == ST_POP_A) begin
         hit_in = !stack_empty;
         if (!stack_empty) begin
            count_in = count_dec;
         end
      end

      if (state_ff == ST_TAKE_B) begin
         b_in = popped;
         if (mode_ff == MODE_LINE_END) begin
            value_in = popped;
         end else if (mode_ff == MODE_DIV && popped == 32'd0) begin
            value_in  = 32'd0;
            status_in = STATUS_ZERO_DIV;
         end
      end

      if (state_ff == ST_CALC && !alu_busy) begin
         value_in = alu_result;
      end

      // After two pops an arithmetic result always finds room; only a plain
      // push can hit a full stack.
      if (state_ff == ST_PUSH) begin
         if (stack_room) begin
            count_in = count_ff + CW'(1);
         end else begin
            status_in = STATUS_FULL;
         end
      end

      if (out_load) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in.value  = value_ff;
         rsp_data_in.status = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      b_ff        <= b_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The stack count never runs past the configured depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count exceeds depth");

   // The arithmetic unit only runs while the sequencer waits for it.
   a_alu_busy_in_calc: assert property (@(posedge clock) disable iff (reset)
      alu_busy |-> state_ff == ST_CALC)
      else $error("arithmetic unit busy outside calculation state");

   // A stack write never lands past the top of the memory.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      stk_ctrl.wr_en |-> (count_ff < CW'(STACK_DEPTH) && state_ff == ST_PUSH))
      else $error("stack write with no room");

   // A zero-divisor beat always carries a zero value.
   a_zero_div_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STATUS_ZERO_DIV) |-> rsp_data_ff.value == 32'd0)
      else $error("zero divisor beat with nonzero value");

   // A new result never overwrites a beat that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while stalled");

endmodule

### src/rsc_stack.sv
module rsc_stack import rsc_pkg::*; #(
   parameter int STACK_DEPTH = RSC_STACK_DEPTH,
   parameter int ADDR_WIDTH  = $clog2(STACK_DEPTH)
) (
   input  logic                  clock,
   input  stk_ctrl_type          ctrl,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [31:0]           wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [31:0]           rd_data
);

   // Stack storage: one write port, one registered read port.
   logic [31:0] mem_ff [STACK_DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/rsc_alu.sv
module rsc_alu import rsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_cmd_type cmd,
   input  logic [31:0] a_opnd,
   input  logic [31:0] b_opnd,
   output logic        busy,
   output logic [31:0] result
);

   // Add and subtract run one bit per cycle through a full adder.
   // Multiply retires one multiplier bit per cycle (shift and add).
   // Divide retires one quotient bit per cycle (restoring).

   function automatic logic [31:0] mag32(input logic [31:0] x);
      return x[31] ? (32'd0 - x) : x;
   endfunction

   function automatic logic [31:0] sat_q16(input logic neg, input logic [47:0] mag);
      logic [31:0] res;
      if (!neg) begin
         res = (mag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end else if (mag > 48'h0000_8000_0000) begin
         res = 32'h8000_0000;
      end else begin
         res = 32'd0 - mag[31:0];
      end
      return res;
   endfunction

   alu_op_type  op_ff,   op_in;
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff,  cnt_in;
   logic        neg_ff,  neg_in;
   logic [32:0] acc_ff,  acc_in;
   logic [47:0] sh_ff,   sh_in;
   logic [31:0] opd_ff,  opd_in;

   logic        sum_bit;
   logic        carry_bit;
   logic [32:0] mul_sum;
   logic [32:0] div_rem;
   logic        div_ge;

   always_comb begin
      sum_bit   = sh_ff[0] ^ opd_ff[0] ^ acc_ff[0];
      carry_bit = (sh_ff[0] & opd_ff[0]) | (acc_ff[0] & (sh_ff[0] ^ opd_ff[0]));
      mul_sum   = {1'b0, acc_ff[31:0]} + (sh_ff[0] ? {1'b0, opd_ff} : 33'd0);
      div_rem   = {acc_ff[31:0], sh_ff[47]};
      div_ge    = (div_rem >= {1'b0, opd_ff});
   end

   always_comb begin
      op_in   = op_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      opd_in  = opd_ff;
      if (cmd.start) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         neg_in  = a_opnd[31] ^ b_opnd[31];
         acc_in  = '0;
         cnt_in  = 6'd31;
         case (cmd.op)
            ALU_ADD: begin
               sh_in  = {16'd0, a_opnd};
               opd_in = b_opnd;
            end
            ALU_SUB: begin
               sh_in  = {16'd0, a_opnd};
               opd_in = ~b_opnd;
               acc_in = 33'd1;
            end
            ALU_MUL: begin
               sh_in  = {16'd0, mag32(b_opnd)};
               opd_in = mag32(a_opnd);
            end
            default: begin
               sh_in  = {mag32(a_opnd), 16'd0};
               opd_in = mag32(b_opnd);
               cnt_in = 6'd47;
            end
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
         end
         case (op_ff)
            ALU_ADD, ALU_SUB: begin
               sh_in  = {16'd0, sum_bit, sh_ff[31:1]};
               opd_in = {1'b0, opd_ff[31:1]};
               acc_in = {32'd0, carry_bit};
            end
            ALU_MUL: begin
               acc_in = {1'b0, mul_sum[32:1]};
               sh_in  = {16'd0, mul_sum[0], sh_ff[31:1]};
            end
            default: begin
               acc_in = div_ge ? (div_rem - {1'b0, opd_ff}) : div_rem;
               sh_in  = {sh_ff[46:0], div_ge};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      opd_ff <= opd_in;
   end

   always_comb begin
      case (op_ff)
         ALU_ADD, ALU_SUB: result = sh_ff[31:0];
         ALU_MUL:          result = sat_q16(neg_ff, {acc_ff[31:0], sh_ff[31:16]});
         default:          result = sat_q16(neg_ff, sh_ff);
      endcase
   end

   assign busy = busy_ff;

endmodule

### tb/rsc_checker.sv
module rsc_checker import rsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      outstanding,
   output int      fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the operand stack.
   logic [31:0] stack_mem [RSC_STACK_DEPTH];
   int unsigned stack_level;

   // Results owed by the block, oldest first.
   rsp_type rpn_answers [$];
   rsp_type want;
   int      errors;

   function automatic logic [31:0] pop_entry();
      if (stack_level > 0) begin
         stack_level--;
         return stack_mem[stack_level];
      end
      return 32'd0;
   endfunction

   function automatic bit push_entry(logic [31:0] v);
      if (stack_level < RSC_STACK_DEPTH) begin
         stack_mem[stack_level] = v;
         stack_level++;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [31:0] abs_q(logic [31:0] x);
      return x[31] ? -x : x;
   endfunction

   // Clamps a sign and magnitude pair into the signed Q16.16 range.
   function automatic logic [31:0] clamp_q(bit neg, logic [63:0] mag);
      if (!neg)
         return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      if (mag > 64'h8000_0000)
         return 32'h8000_0000;
      return -mag[31:0];
   endfunction

   function automatic logic [31:0] q_mul(logic [31:0] a, logic [31:0] b);
      logic [63:0] prod;
      prod = {32'd0, abs_q(a)} * {32'd0, abs_q(b)};
      return clamp_q(a[31] ^ b[31], prod >> 16);
   endfunction

   function automatic logic [31:0] q_div(logic [31:0] a, logic [31:0] b);
      logic [63:0] num;
      logic [63:0] den;
      num = {16'd0, abs_q(a), 16'd0};
      den = {32'd0, abs_q(b)};
      return clamp_q(a[31] ^ b[31], num / den);
   endfunction

   // Applies one token to the shadow stack and returns the result it owes.
   function automatic rsp_type evaluate_token(req_type tok);
      logic [31:0] a;
      logic [31:0] b;
      rsp_type     r;
      r.value  = '0;
      r.status = STATUS_OK;
      case (tok.mode)
         MODE_PUSH: begin
            r.value = tok.operand;
            if (!push_entry(tok.operand))
               r.status = STATUS_FULL;
         end
         MODE_ADD, MODE_SUB, MODE_MUL: begin
            b = pop_entry();
            a = pop_entry();
            if (tok.mode == MODE_ADD)
               r.value = a + b;
            else if (tok.mode == MODE_SUB)
               r.value = a - b;
            else
               r.value = q_mul(a, b);
            void'(push_entry(r.value));
         end
         MODE_DIV: begin
            b = pop_entry();
            if (b == 32'd0) begin
               r.status = STATUS_ZERO_DIV;
            end else begin
               a = pop_entry();
               r.value = q_div(a, b);
               void'(push_entry(r.value));
            end
         end
         MODE_LINE_END: begin
            r.value = pop_entry();
         end
         default: begin
            r.status = STATUS_UNKNOWN;
         end
      endcase
      return r;
   endfunction

   // Results are compared before the same edge's token is predicted, since a
   // result beat always belongs to an earlier token.
   always @(posedge clock) begin
      if (reset) begin
         rpn_answers.delete();
         stack_level = 0;
         errors      = 0;
         outstanding <= 0;
         fail_count  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rpn_answers.size() == 0) begin
               $display("%0t: result beat with none expected, value %h status %0d",
                        $time, rsp_data.value, rsp_data.status);
               errors++;
            end else begin
               want = rpn_answers.pop_front();
               if (rsp_data.value !== want.value) begin
                  $display("%0t: value mismatch, expected %h, got %h",
                           $time, want.value, rsp_data.value);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_data.status);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall)
            rpn_answers.push_back(evaluate_token(req_data));
         outstanding <= rpn_answers.size();
         fail_count  <= errors;
      end
   end

endmodule

### tb/tb_top.sv
module tb_top;
   import rsc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Mode 7 has no meaning of its own; the block must treat it as unknown.
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   // Longest run of cycles with no beat on either channel before the run is
   // declared hung.
   localparam int IDLE_LIMIT = 2000;

   // Cycles to linger after the last result, covering the slowest token.
   localparam int TAIL_CYCLES = 60;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int outstanding;
   int fail_count;
   int idle_cycles = 0;
   int sent_tokens = 0;
   int stall_left  = 0;
   int rsp_beats   = 0;

   rpn_stack_calculator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The checker watches both channels, keeps its own stack and compares
   // every result beat against the prediction for the oldest open token.
   rsc_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Result side back-pressure. A stall length is drawn after each accepted
   // beat and is counted down only while a result is on offer, so the stall
   // really holds a beat back. Every 96 beats, a run of 32 beats goes through
   // with no stall at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         rsp_beats  = 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_beats++;
         stall_left = ((rsp_beats % 96) < 32) ? 0 : $urandom_range(0, 17);
         rsp_stall <= (stall_left != 0);
      end else if (rsp_valid && stall_left != 0) begin
         stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   // Watchdog: a cycle with a beat on either channel restarts the count. If the
   // block stops moving, or an expected result never shows up, the run ends.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Operand mix: mostly modest Q16.16 values so that products and quotients
   // stay interesting, plus the range ends, zero for divide by zero, and full
   // random words so that every bit is seen at both levels.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: begin
            case ($urandom_range(0, 6))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               3: return 32'h0000_0001;
               4: return 32'h0001_0000;
               5: return 32'hFFFF_0000;
               default: return 32'h0000_0000;
            endcase
         end
         2: return 32'h0000_0000;
         3, 4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      endcase
   endfunction

   // Offers one token and returns at the edge where it is accepted. The gap
   // before it is drawn at random, except in stretches of 30 tokens out of
   // every 100 that go back to back. Valid stays high between back-to-back
   // tokens and is lowered only when a gap follows or all results are awaited.
   task automatic send_token(input logic [2:0] mode, input logic [31:0] operand);
      int      gap;
      req_type tok;
      gap = ((sent_tokens % 100) < 30) ? 0 : $urandom_range(0, 17);
      sent_tokens++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      tok.mode    = mode;
      tok.operand = operand;
      req_valid <= 1'b1;
      req_data  <= tok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Random tokens weighted so that pushes roughly balance the pops and the
   // stack wanders at shallow depths: most operators find real operands, and
   // now and then one runs into an empty stack. A few tokens are unknown.
   task automatic random_tokens(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 46)
            send_token(MODE_PUSH, pick_operand());
         else if (pick < 55)
            send_token(MODE_ADD, $urandom());
         else if (pick < 64)
            send_token(MODE_SUB, $urandom());
         else if (pick < 73)
            send_token(MODE_MUL, $urandom());
         else if (pick < 82)
            send_token(MODE_DIV, $urandom());
         else if (pick < 94)
            send_token(MODE_LINE_END, $urandom());
         else if (pick < 98)
            send_token(MODE_UNKNOWN, $urandom());
         else
            send_token(MODE_UNUSED, $urandom());
      end
   endtask

   // Holds the request channel idle until every open token has its result.
   // The first edge lets the count take in a token accepted just now.
   task automatic wait_all_answered();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty stack behavior: line end pops zero, an operator works on zeros,
      // and a divide finds a zero divisor. Unknown and meaningless modes only
      // flag. Operators carry random operands, which must be ignored.
      send_token(MODE_LINE_END, $urandom());
      send_token(MODE_SUB, $urandom());
      send_token(MODE_LINE_END, $urandom());
      send_token(MODE_DIV, $urandom());
      send_token(MODE_UNKNOWN, $urandom());
      send_token(MODE_UNUSED, $urandom());

      // Add wraps past the top of the range.
      send_token(MODE_PUSH, 32'h7FFF_FFFF);
      send_token(MODE_PUSH, 32'h0000_0001);
      send_token(MODE_ADD, $urandom());

      // Most negative times most negative saturates high, then times most
      // negative again saturates low.
      send_token(MODE_PUSH, 32'h8000_0000);
      send_token(MODE_MUL, $urandom());
      send_token(MODE_PUSH, 32'h8000_0000);
      send_token(MODE_MUL, $urandom());

      // A zero divisor is consumed and the dividend stays; then dividing the
      // most negative value by the smallest negative step saturates high.
      send_token(MODE_PUSH, 32'h0000_0000);
      send_token(MODE_DIV, $urandom());
      send_token(MODE_PUSH, 32'hFFFF_FFFF);
      send_token(MODE_DIV, $urandom());

      // Ordinary fractional arithmetic on the saturated value.
      send_token(MODE_PUSH, 32'h0003_0000);
      send_token(MODE_SUB, $urandom());
      send_token(MODE_PUSH, 32'hFFFE_0000);
      send_token(MODE_DIV, $urandom());
      send_token(MODE_PUSH, 32'h0001_8000);
      send_token(MODE_MUL, $urandom());
      send_token(MODE_LINE_END, $urandom());
      send_token(MODE_LINE_END, $urandom());

      random_tokens(350);

      // Fill the stack past its depth so that pushes get dropped and flagged,
      // then mix in random tokens while it sits near full.
      for (int i = 0; i < 136; i++)
         send_token(MODE_PUSH, pick_operand());
      random_tokens(12);

      // Let the block run dry before emptying the stack again.
      wait_all_answered();
      for (int i = 0; i < 130; i++)
         send_token(MODE_LINE_END, $urandom());

      random_tokens(200);

      wait_all_answered();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

### filelist.f
src/rsc_pkg.sv
src/rsc_stack.sv
src/rsc_alu.sv
src/rpn_stack_calculator_core.sv
tb/rsc_checker.sv
tb/tb_top.sv
